>>> design/scf_pkg.sv
// shared types, constants and the control store for the ramped stereo crossfader
// used by scf_sequencer, scf_datapath and the top level; depends on nothing
package scf_pkg;

   localparam int SAMPLE_W       = 24;
   localparam int POS_W          = 17;
   localparam int CFG_W          = 13;
   localparam int GAIN_W         = 33;
   localparam int MUL_A_W        = 25;
   localparam int MUL_B_W        = 34;
   localparam int PROD_W         = MUL_A_W + MUL_B_W;
   localparam int ACC_W          = 58;
   localparam int QUOT_W         = 17;
   localparam int LOOP_W         = 5;
   localparam int MAX_FRAMES_DEF = 4096;
   localparam int LEN_LIMIT      = 8191;

   localparam logic [POS_W-1:0] Q16_ONE   = POS_W'(65536);
   localparam logic [CFG_W-1:0] FPB_RESET = CFG_W'(256);
   localparam logic [LOOP_W-1:0] DIV_LAST = LOOP_W'(QUOT_W - 1);

   typedef enum logic [3:0] {
      STEP_WAIT,
      STEP_MAG,
      STEP_DIV,
      STEP_POS,
      STEP_GAIN_P,
      STEP_MUL_L,
      STEP_MUL_R,
      STEP_GAIN_S,
      STEP_ADD_L,
      STEP_ADD_R,
      STEP_OUT
   } step_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_DIV_INIT,
      OP_DIV,
      OP_POS,
      OP_GAIN,
      OP_ACC_L_SET,
      OP_ACC_R_SET,
      OP_ACC_L_ADD,
      OP_ACC_R_ADD,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      A_DIFF,
      A_PL,
      A_PR,
      A_SL,
      A_SR,
      A_P,
      A_GP_BASE
   } a_sel_type;

   typedef enum logic [1:0] {
      B_IDX,
      B_GAIN,
      B_P,
      B_GP_BASE
   } b_sel_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_NO_REQ,
      HOLD_LOOP,
      HOLD_BUSY
   } hold_type;

   typedef enum logic [1:0] {
      BR_NEVER,
      BR_ALWAYS,
      BR_NOT_BOTH
   } branch_type;

   typedef struct packed {
      op_type     op;
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      hold_type   hold;
      branch_type branch;
      step_type   target;
      logic       take_req;
      logic       loop_init;
   } ctl_type;

   typedef struct packed {
      logic both;
      logic out_busy;
   } status_type;

   // microprogram: one control word per step
   function automatic ctl_type rom_word(step_type s);
      ctl_type w;
      w = '{op: OP_NONE, a_sel: A_DIFF, b_sel: B_IDX, hold: HOLD_NONE,
            branch: BR_NEVER, target: STEP_WAIT, take_req: 1'b0, loop_init: 1'b0};
      unique case (s)
         STEP_WAIT: begin
            w.hold     = HOLD_NO_REQ;
            w.take_req = 1'b1;
         end
         STEP_MAG: begin
            w.op        = OP_DIV_INIT;
            w.a_sel     = A_DIFF;
            w.b_sel     = B_IDX;
            w.loop_init = 1'b1;
         end
         STEP_DIV: begin
            w.op   = OP_DIV;
            w.hold = HOLD_LOOP;
         end
         STEP_POS: begin
            w.op = OP_POS;
         end
         STEP_GAIN_P: begin
            w.op    = OP_GAIN;
            w.a_sel = A_GP_BASE;
            w.b_sel = B_GP_BASE;
         end
         STEP_MUL_L: begin
            w.op    = OP_ACC_L_SET;
            w.a_sel = A_PL;
            w.b_sel = B_GAIN;
         end
         STEP_MUL_R: begin
            w.op     = OP_ACC_R_SET;
            w.a_sel  = A_PR;
            w.b_sel  = B_GAIN;
            w.branch = BR_NOT_BOTH;
            w.target = STEP_OUT;
         end
         STEP_GAIN_S: begin
            w.op    = OP_GAIN;
            w.a_sel = A_P;
            w.b_sel = B_P;
         end
         STEP_ADD_L: begin
            w.op    = OP_ACC_L_ADD;
            w.a_sel = A_SL;
            w.b_sel = B_GAIN;
         end
         STEP_ADD_R: begin
            w.op    = OP_ACC_R_ADD;
            w.a_sel = A_SR;
            w.b_sel = B_GAIN;
         end
         STEP_OUT: begin
            w.op     = OP_OUT;
            w.hold   = HOLD_BUSY;
            w.branch = BR_ALWAYS;
            w.target = STEP_WAIT;
         end
         default: begin
            w.branch = BR_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

>>> design/stereo_crossfader_ramped_unit.sv
// top level of the ramped square-law stereo crossfader
// depends on scf_pkg, scf_sequencer and scf_datapath
//
// One stereo word in gives one faded stereo word out. Between acceptance and
// the load of its result into the output register, one step forms the ramp
// product, 17 restoring divide steps give the ramp position, one step forms
// the position and its complement, then the single shared 25x34 multiplier
// makes the gain and both products, and in three further steps the secondary
// gain and terms when both sources are on, all sequenced by a microprogram.
// The input reopens in the cycle after the load. A result stalled in the
// output register holds the sequencer at its last step until the register
// frees up. A new word is taken as soon as the previous result sits in the
// output register, even if that result has not been taken yet. The user must
// write frames_per_block through the csr port only while no word is in
// flight; the block itself does not enforce this.
module stereo_crossfader_ramped_unit #(
   parameter int MAX_FRAMES = scf_pkg::MAX_FRAMES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_first_of_block,
   input  logic signed [scf_pkg::SAMPLE_W-1:0] req_primary_left,
   input  logic signed [scf_pkg::SAMPLE_W-1:0] req_primary_right,
   input  logic signed [scf_pkg::SAMPLE_W-1:0] req_secondary_left,
   input  logic signed [scf_pkg::SAMPLE_W-1:0] req_secondary_right,
   input  logic                                req_primary_present,
   input  logic                                req_secondary_present,
   input  logic                                req_hold_position,
   input  logic [scf_pkg::POS_W-1:0]           req_start_position,
   input  logic [scf_pkg::POS_W-1:0]           req_target_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [scf_pkg::SAMPLE_W-1:0] rsp_out_left,
   output logic signed [scf_pkg::SAMPLE_W-1:0] rsp_out_right,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scf_pkg::CFG_W-1:0]           csr_data
);

   scf_pkg::ctl_type    ctl;
   scf_pkg::status_type status;
   logic                accept;

   assign req_stall = !ctl.take_req;
   assign accept    = req_valid && ctl.take_req;
   assign csr_ready = 1'b1;

   scf_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctl       (ctl)
   );

   scf_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .accept            (accept),
      .first_of_block    (req_first_of_block),
      .primary_left      (req_primary_left),
      .primary_right     (req_primary_right),
      .secondary_left    (req_secondary_left),
      .secondary_right   (req_secondary_right),
      .primary_present   (req_primary_present),
      .secondary_present (req_secondary_present),
      .hold_position     (req_hold_position),
      .start_position    (req_start_position),
      .target_position   (req_target_position),
      .cfg_write         (csr_valid && csr_ready),
      .cfg_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .out_left          (rsp_out_left),
      .out_right         (rsp_out_right),
      .status            (status)
   );

endmodule

>>> design/scf_sequencer.sv
// step counter, loop counter and control store lookup for the crossfader
// depends on scf_pkg; drives the control word into scf_datapath
module scf_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  scf_pkg::status_type  status,
   output scf_pkg::ctl_type     ctl
);

   scf_pkg::step_type               step_ff, step_in;
   logic [scf_pkg::LOOP_W-1:0]      loop_ff, loop_in;
   logic                            hold_c;
   logic                            jump_c;

   assign ctl = scf_pkg::rom_word(step_ff);

   always_comb begin
      unique case (ctl.hold)
         scf_pkg::HOLD_NONE:   hold_c = 1'b0;
         scf_pkg::HOLD_NO_REQ: hold_c = !req_valid;
         scf_pkg::HOLD_LOOP:   hold_c = (loop_ff != '0);
         scf_pkg::HOLD_BUSY:   hold_c = status.out_busy;
         default:              hold_c = 1'b0;
      endcase
      unique case (ctl.branch)
         scf_pkg::BR_NEVER:    jump_c = 1'b0;
         scf_pkg::BR_ALWAYS:   jump_c = 1'b1;
         scf_pkg::BR_NOT_BOTH: jump_c = !status.both;
         default:              jump_c = 1'b1;
      endcase
   end

   always_comb begin
      priority if (hold_c) begin
         step_in = step_ff;
      end else if (jump_c) begin
         step_in = ctl.target;
      end else begin
         step_in = scf_pkg::step_type'(step_ff + 4'd1);
      end
      priority if (ctl.loop_init) begin
         loop_in = scf_pkg::DIV_LAST;
      end else if (ctl.op == scf_pkg::OP_DIV && loop_ff != '0) begin
         loop_in = loop_ff - 1'b1;
      end else begin
         loop_in = loop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= scf_pkg::STEP_WAIT;
         loop_ff <= '0;
      end else begin
         step_ff <= step_in;
         loop_ff <= loop_in;
      end
   end

endmodule

>>> design/scf_datapath.sv
// operand registers, shared multiplier, restoring divider, accumulators and
// output register of the crossfader; depends on scf_pkg, steered by scf_sequencer
module scf_datapath #(
   parameter int MAX_FRAMES = scf_pkg::MAX_FRAMES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  scf_pkg::ctl_type                    ctl,
   input  logic                                accept,
   input  logic                                first_of_block,
   input  logic signed [scf_pkg::SAMPLE_W-1:0] primary_left,
   input  logic signed [scf_pkg::SAMPLE_W-1:0] primary_right,
   input  logic signed [scf_pkg::SAMPLE_W-1:0] secondary_left,
   input  logic signed [scf_pkg::SAMPLE_W-1:0] secondary_right,
   input  logic                                primary_present,
   input  logic                                secondary_present,
   input  logic                                hold_position,
   input  logic [scf_pkg::POS_W-1:0]           start_position,
   input  logic [scf_pkg::POS_W-1:0]           target_position,
   input  logic                                cfg_write,
   input  logic [scf_pkg::CFG_W-1:0]           cfg_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [scf_pkg::SAMPLE_W-1:0] out_left,
   output logic signed [scf_pkg::SAMPLE_W-1:0] out_right,
   output scf_pkg::status_type                 status
);

   localparam int LEN_CAP = (MAX_FRAMES > scf_pkg::LEN_LIMIT) ? scf_pkg::LEN_LIMIT : MAX_FRAMES;
   localparam int IDX_W   = (LEN_CAP > 2) ? $clog2(LEN_CAP) : 1;
   localparam int LEN_W   = scf_pkg::CFG_W;
   localparam int RND_W   = scf_pkg::ACC_W - 32;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_CAP);

   logic [LEN_W-1:0]                  fpb_ff;
   logic [LEN_W-1:0]                  len_c;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [LEN_W:0]                    idx_inc;

   logic signed [scf_pkg::SAMPLE_W-1:0] pl_ff, pr_ff, sl_ff, sr_ff;
   logic                              a_on_ff, b_on_ff, hold_ff;
   logic [scf_pkg::POS_W-1:0]         start_ff, target_ff;
   logic [scf_pkg::POS_W-1:0]         absdiff_c;
   logic                              down_c;

   logic [LEN_W-1:0]                  rem_ff;
   logic [scf_pkg::QUOT_W-1:0]        quot_ff;
   logic [LEN_W:0]                    trial_c;
   logic                              qbit_c;

   logic [scf_pkg::POS_W-1:0]         p_ff, inv_ff, p_c;
   logic [scf_pkg::GAIN_W-1:0]        gain_ff;
   logic signed [scf_pkg::ACC_W-1:0]  acc_l_ff, acc_r_ff;

   logic signed [scf_pkg::MUL_A_W-1:0] mul_a;
   logic signed [scf_pkg::MUL_B_W-1:0] mul_b;
   logic signed [scf_pkg::PROD_W-1:0]  prod;
   logic signed [scf_pkg::ACC_W-1:0]   prod_acc;

   logic                              rsp_valid_ff;
   logic signed [scf_pkg::SAMPLE_W-1:0] out_l_ff, out_r_ff;
   logic                              out_busy;
   logic                              out_load;

   function automatic logic [scf_pkg::POS_W-1:0] clamp_pos(logic [scf_pkg::POS_W-1:0] v);
      return (v > scf_pkg::Q16_ONE) ? scf_pkg::Q16_ONE : v;
   endfunction

   // round half up at bit 31, drop 32 fraction bits, clip to 24 bits
   function automatic logic signed [scf_pkg::SAMPLE_W-1:0] round_sat(
      logic signed [scf_pkg::ACC_W-1:0] acc);
      logic signed [scf_pkg::ACC_W-1:0] biased;
      logic signed [RND_W-1:0]          r;
      biased = acc + (scf_pkg::ACC_W'(1) <<< 31);
      r      = biased[scf_pkg::ACC_W-1:32];
      if (r > RND_W'(8388607)) begin
         return scf_pkg::SAMPLE_W'(8388607);
      end else if (r < -RND_W'(8388608)) begin
         return -scf_pkg::SAMPLE_W'(8388608);
      end
      return r[scf_pkg::SAMPLE_W-1:0];
   endfunction

   // effective block length
   always_comb begin
      priority if (fpb_ff == '0) begin
         len_c = LEN_W'(1);
      end else if (fpb_ff > LEN_MAX) begin
         len_c = LEN_MAX;
      end else begin
         len_c = fpb_ff;
      end
   end

   assign idx_inc   = (LEN_W + 1)'(idx_ff) + 1'b1;
   assign down_c    = target_ff < start_ff;
   assign absdiff_c = down_c ? (start_ff - target_ff) : (target_ff - start_ff);

   // shared multiplier operand selection
   always_comb begin
      unique case (ctl.a_sel)
         scf_pkg::A_DIFF:    mul_a = signed'(scf_pkg::MUL_A_W'(absdiff_c));
         scf_pkg::A_PL:      mul_a = scf_pkg::MUL_A_W'(pl_ff);
         scf_pkg::A_PR:      mul_a = scf_pkg::MUL_A_W'(pr_ff);
         scf_pkg::A_SL:      mul_a = scf_pkg::MUL_A_W'(sl_ff);
         scf_pkg::A_SR:      mul_a = scf_pkg::MUL_A_W'(sr_ff);
         scf_pkg::A_P:       mul_a = signed'(scf_pkg::MUL_A_W'(p_ff));
         scf_pkg::A_GP_BASE: mul_a = signed'(scf_pkg::MUL_A_W'(a_on_ff ? inv_ff : p_ff));
         default:            mul_a = '0;
      endcase
      unique case (ctl.b_sel)
         scf_pkg::B_IDX:     mul_b = signed'(scf_pkg::MUL_B_W'(idx_ff));
         scf_pkg::B_GAIN:    mul_b = signed'(scf_pkg::MUL_B_W'(gain_ff));
         scf_pkg::B_P:       mul_b = signed'(scf_pkg::MUL_B_W'(p_ff));
         scf_pkg::B_GP_BASE: mul_b = signed'(scf_pkg::MUL_B_W'(a_on_ff ? inv_ff : p_ff));
         default:            mul_b = '0;
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign prod_acc = prod[scf_pkg::ACC_W-1:0];

   // one restoring divide step
   assign trial_c = {rem_ff, quot_ff[scf_pkg::QUOT_W-1]};
   assign qbit_c  = trial_c >= (LEN_W + 1)'(len_c);

   always_comb begin
      if (hold_ff) begin
         p_c = target_ff;
      end else if (down_c) begin
         p_c = start_ff - quot_ff;
      end else begin
         p_c = start_ff + quot_ff;
      end
   end

   assign out_busy = rsp_valid_ff && rsp_stall;
   assign out_load = (ctl.op == scf_pkg::OP_OUT) && !out_busy;

   always_comb begin
      idx_in = idx_ff;
      if (accept && first_of_block) begin
         idx_in = '0;
      end else if (out_load) begin
         idx_in = (idx_inc >= (LEN_W + 1)'(len_c)) ? '0 : idx_inc[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fpb_ff       <= scf_pkg::FPB_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            fpb_ff <= cfg_data;
         end
         idx_ff <= idx_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pl_ff     <= primary_left;
         pr_ff     <= primary_right;
         sl_ff     <= secondary_left;
         sr_ff     <= secondary_right;
         a_on_ff   <= primary_present;
         b_on_ff   <= secondary_present;
         hold_ff   <= hold_position;
         start_ff  <= clamp_pos(start_position);
         target_ff <= clamp_pos(target_position);
      end
      unique case (ctl.op)
         scf_pkg::OP_DIV_INIT: begin
            // quotient stays below 2^17, so the upper bits start below len
            rem_ff  <= prod[scf_pkg::QUOT_W +: LEN_W];
            quot_ff <= prod[scf_pkg::QUOT_W-1:0];
         end
         scf_pkg::OP_DIV: begin
            rem_ff  <= qbit_c ? LEN_W'(trial_c - (LEN_W + 1)'(len_c)) : trial_c[LEN_W-1:0];
            quot_ff <= {quot_ff[scf_pkg::QUOT_W-2:0], qbit_c};
         end
         scf_pkg::OP_POS: begin
            p_ff   <= p_c;
            inv_ff <= scf_pkg::Q16_ONE - p_c;
         end
         scf_pkg::OP_GAIN:      gain_ff  <= prod[scf_pkg::GAIN_W-1:0];
         scf_pkg::OP_ACC_L_SET: acc_l_ff <= prod_acc;
         scf_pkg::OP_ACC_R_SET: acc_r_ff <= prod_acc;
         scf_pkg::OP_ACC_L_ADD: acc_l_ff <= acc_l_ff + prod_acc;
         scf_pkg::OP_ACC_R_ADD: acc_r_ff <= acc_r_ff + prod_acc;
         scf_pkg::OP_OUT: begin
            if (!out_busy) begin
               out_l_ff <= round_sat(acc_l_ff);
               out_r_ff <= round_sat(acc_r_ff);
            end
         end
         scf_pkg::OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign out_left        = out_l_ff;
   assign out_right       = out_r_ff;
   assign status.both     = a_on_ff && b_on_ff;
   assign status.out_busy = out_busy;

endmodule

>>> design/scf_checker.sv
// port-level checks for stereo_crossfader_ramped_unit, attached by bind
// depends on scf_pkg for field widths
module scf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [scf_pkg::SAMPLE_W-1:0] rsp_out_left,
   input logic signed [scf_pkg::SAMPLE_W-1:0] rsp_out_right
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_left) && $stable(rsp_out_right))
      else $error("stalled result word changed");

   // one word at a time: accepting closes the input side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accepting a word");

   // a fresh result cannot show up the cycle after a word is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a new result is loaded only on the way back to waiting for input
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result loaded while still busy");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stereo_crossfader_ramped_unit scf_checker u_scf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_left  (rsp_out_left),
   .rsp_out_right (rsp_out_right)
);
